// ===== rtl/core/lfd_pkg.sv =====
// Shared constants and types for the length-prefixed frame deframer.
package lfd_pkg;

  // Number of length bytes after the start byte, least significant first.
  localparam int unsigned LENGTH_BYTES = 4;
  localparam int unsigned LEN_W        = 8 * LENGTH_BYTES;
  localparam int unsigned CNT_W        = 3;

  // Frame parser phases, one-hot.
  typedef enum logic [3:0] {
    PH_HUNT    = 4'b0001,
    PH_LENGTH  = 4'b0010,
    PH_PAYLOAD = 4'b0100,
    PH_CHECK   = 4'b1000
  } lfd_phase_t;

  // One result word as it travels to the output register.
  typedef struct packed {
    logic [7:0] data;
    logic       is_payload;
    logic       frame_end;
    logic       frame_good;
  } lfd_result_t;

endpackage

// ===== rtl/core/length_prefixed_frame_deframer.sv =====
// Top level of the length-prefixed frame deframer with additive checksum.
//
// Input channel: in_valid / in_stall carry one received word (in_rx_byte)
// per accepted cycle. Bytes other than the start marker are dropped while
// hunting; a start byte is followed by four little-endian length bytes, the
// payload bytes and one checksum byte.
// Result channel: out_valid / out_stall carry one result per payload byte
// (out_is_payload set) and one frame-end result (out_frame_end set, with
// out_frame_good telling whether the 8-bit wrapping sum matched).
// Start, length and hunting bytes give no result.
// Configuration: cfg_wr_en writes cfg_wr_data into the start marker.
// A word passes through the input register and then the output register
// before out_valid rises for its result.
// One word is taken every cycle while the receiver does not stall; the input
// register, parser and output register each handle one word per clock.
// Synchronous reset returns the parser to hunting, empties both registers
// and sets the start marker to zero.
// When the receiver stalls, the output register holds its word and the
// input register fills; in_stall then rises until the output drains.
module length_prefixed_frame_deframer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_is_payload,
  output logic       out_frame_end,
  output logic       out_frame_good,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data
);
  import lfd_pkg::*;

  logic [7:0]  marker_r;
  logic        item_valid;
  logic [7:0]  item_byte;
  logic        out_free;
  logic        take;
  logic        res_valid;
  lfd_result_t res;

  // Start marker register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      marker_r <= '0;
    end else if (cfg_wr_en) begin
      marker_r <= cfg_wr_data;
    end
  end

  // A word is consumed when the output register can accept its result.
  assign take = item_valid && out_free;

  lfd_in u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_rx_byte (in_rx_byte),
    .in_stall   (in_stall),
    .take       (take),
    .item_valid (item_valid),
    .item_byte  (item_byte)
  );

  lfd_fsm u_fsm (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (take),
    .item_byte    (item_byte),
    .start_marker (marker_r),
    .res_valid    (res_valid),
    .res          (res)
  );

  lfd_out u_out (
    .clk            (clk),
    .rst_n          (rst_n),
    .res_valid      (res_valid),
    .res            (res),
    .free           (out_free),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_is_payload (out_is_payload),
    .out_frame_end  (out_frame_end),
    .out_frame_good (out_frame_good)
  );
endmodule

// ===== rtl/core/lfd_in.sv =====
// Input register stage: captures one received word and holds it until used.
module lfd_in (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [7:0] in_rx_byte,
  output logic       in_stall,
  input  logic       take,
  output logic       item_valid,
  output logic [7:0] item_byte
);
  import lfd_pkg::*;

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] byte_r;
  logic       load;

  // The stage can load whenever it is empty or its word leaves this cycle.
  assign in_stall = valid_r && !take;
  assign load     = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload register needs no reset.
  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= in_rx_byte;
    end
  end

  assign item_valid = valid_r;
  assign item_byte  = byte_r;
endmodule

// ===== rtl/core/lfd_fsm.sv =====
// Frame parser: hunts for the start byte, collects length, sums payload, checks.
module lfd_fsm (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  logic [7:0]           item_byte,
  input  logic [7:0]           start_marker,
  output logic                 res_valid,
  output lfd_pkg::lfd_result_t res
);
  import lfd_pkg::*;

  lfd_phase_t         phase_r, phase_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [LEN_W-1:0]   remain_r, remain_nxt;
  logic [7:0]         sum_r, sum_nxt;
  logic [LEN_W-1:0]   len_merged;
  logic [LEN_W-1:0]   remain_dec;
  logic [CNT_W-1:0]   cnt_inc;

  // Place the incoming length byte into its lane; lanes not yet filled still hold zero.
  always_comb begin
    len_merged = remain_r;
    for (int i = 0; i < LENGTH_BYTES; i++) begin
      if (cnt_r == CNT_W'(i)) begin
        len_merged[8*i +: 8] = item_byte;
      end
    end
  end

  assign remain_dec = remain_r - LEN_W'(1);
  assign cnt_inc    = cnt_r + CNT_W'(1);

  // Next state and result for the word being processed.
  always_comb begin
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    remain_nxt = remain_r;
    sum_nxt    = sum_r;
    res_valid  = 1'b0;
    res        = '0;
    res.data   = item_byte;
    case (phase_r)
      PH_HUNT: begin
        if (item_byte == start_marker) begin
          phase_nxt  = PH_LENGTH;
          cnt_nxt    = '0;
          remain_nxt = '0;
          sum_nxt    = '0;
        end
      end
      PH_LENGTH: begin
        remain_nxt = len_merged;
        cnt_nxt    = cnt_inc;
        if (cnt_inc >= CNT_W'(LENGTH_BYTES)) begin
          phase_nxt = (len_merged == '0) ? PH_CHECK : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        sum_nxt        = sum_r + item_byte;
        remain_nxt     = remain_dec;
        res_valid      = step;
        res.is_payload = 1'b1;
        if (remain_dec == '0) begin
          phase_nxt = PH_CHECK;
        end
      end
      PH_CHECK: begin
        res_valid      = step;
        res.frame_end  = 1'b1;
        res.frame_good = (item_byte == sum_r);
        phase_nxt      = PH_HUNT;
        cnt_nxt        = '0;
        remain_nxt     = '0;
        sum_nxt        = '0;
      end
      default: begin
        phase_nxt  = PH_HUNT;
        cnt_nxt    = '0;
        remain_nxt = '0;
        sum_nxt    = '0;
      end
    endcase
  end

  // Parser state moves only when a word is consumed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HUNT;
      cnt_r    <= '0;
      remain_r <= '0;
      sum_r    <= '0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      cnt_r    <= cnt_nxt;
      remain_r <= remain_nxt;
      sum_r    <= sum_nxt;
    end
  end
endmodule

// ===== rtl/core/lfd_out.sv =====
// Output register stage: holds one result word until the receiver takes it.
module lfd_out (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 res_valid,
  input  lfd_pkg::lfd_result_t res,
  output logic                 free,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           out_byte,
  output logic                 out_is_payload,
  output logic                 out_frame_end,
  output logic                 out_frame_good
);
  import lfd_pkg::*;

  logic        valid_r;
  logic        valid_nxt;
  lfd_result_t res_r;

  // The register can take a new word when empty or being drained now.
  assign free = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (res_valid) begin
      valid_nxt = 1'b1;
    end else if (free) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      res_r <= res;
    end
  end

  assign out_valid      = valid_r;
  assign out_byte       = res_r.data;
  assign out_is_payload = res_r.is_payload;
  assign out_frame_end  = res_r.frame_end;
  assign out_frame_good = res_r.frame_good;
endmodule
